/* design/load_bank_relay_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Load bank relay sequencer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef LOAD_BANK_RELAY_SEQUENCER_ASSERT_SVH
`define LOAD_BANK_RELAY_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lbrs_pkg.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer package
// Field widths, timing constants, phase and register codes, and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lbrs_pkg;

	localparam int CUR_W     = 15;
	localparam int MASK_W    = 4;
	localparam int PHASE_W   = 2;
	localparam int ACTIVE_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 15;

	localparam int PCD_W   = 14;
	localparam int SCD_W   = 8;
	localparam int PRE_W   = 10;
	localparam int STEP_W  = 8;
	localparam int ELAP_W  = 16;

	localparam logic [PCD_W-1:0]  PROBE_MS_RUN    = 14'd15000;
	localparam logic [PCD_W-1:0]  PROBE_MS_TEST   = 14'd2000;
	localparam logic [PCD_W-1:0]  PROBE_CUT_BELOW = 14'd14750;
	localparam logic [SCD_W-1:0]  SETTLE_MS       = 8'd150;
	localparam logic [ELAP_W-1:0] RESTART_SECONDS = 16'd2700;
	localparam logic [ELAP_W-1:0] ELAPSED_MAX     = 16'hFFFF;
	localparam logic [STEP_W-1:0] SHED_WAIT_RUN   = 8'd120;
	localparam logic [STEP_W-1:0] SHED_WAIT_TEST  = 8'd5;
	localparam logic [STEP_W-1:0] SPACING_RUN     = 8'd5;
	localparam logic [STEP_W-1:0] SPACING_TEST    = 8'd2;
	localparam logic [STEP_W-1:0] FIRST_SPACING   = 8'd5;
	localparam logic [PRE_W-1:0]  MS_PER_SECOND   = 10'd1000;
	localparam logic [CUR_W-1:0]  LIMIT_RESET     = 15'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE     = 1'b1;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_READING = 1'b1;

	typedef enum logic [PHASE_W-1:0] {
		PH_PROBE  = 2'd0,
		PH_SETTLE = 2'd1,
		PH_WAIT   = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sort_round;
		logic sort_odd;
		logic launch;
		logic publish;
	} lbrs_cmd_t;

	typedef struct packed {
		logic sort_req;
		logic out_free;
	} lbrs_status_t;

endpackage

/* design/lbrs_channels.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface lbrs_in_if
	import lbrs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             func;
	logic [CUR_W-1:0] current_sq;

	modport source (output valid, func, current_sq, input ready);
	modport sink (input valid, func, current_sq, output ready);
endinterface

interface lbrs_out_if
	import lbrs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MASK_W-1:0]   relay_mask;
	logic [PHASE_W-1:0]  phase;
	logic [ACTIVE_W-1:0] active_banks;

	modport source (output valid, relay_mask, phase, active_banks, input ready);
	modport sink (input valid, relay_mask, phase, active_banks, output ready);
endinterface

/* design/load_bank_relay_sequencer.sv */
// A result is offered once its item has passed the controller's capture, update
// and publish steps; the reading that ends the last bank's probe also passes
// the odd-even sort rounds in the datapath lanes and a launch step.
// A new item is taken only after the last one is published, and publishing
// waits while the result side has not taken the previous result.
// Reset (arst_n low): phase awaiting start, all relays open, limit 100.
// ----------------------------------------------------------------------------
// Load bank relay sequencer
// Probes, orders and switches load banks under a mean-square current limit.
// ----------------------------------------------------------------------------
module load_bank_relay_sequencer
	import lbrs_pkg::*;
#(
	parameter int NUM_BANKS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	lbrs_in_if.sink              items,
	lbrs_out_if.source           results
);

	lbrs_cmd_t    cmd;
	lbrs_status_t status;

	lbrs_ctrl #(
		.NUM_BANKS(NUM_BANKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(items.valid),
		.in_ready(items.ready),
		.status  (status),
		.cmd     (cmd)
	);

	lbrs_dpath #(
		.NUM_BANKS(NUM_BANKS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (items.func),
		.current_sq  (items.current_sq),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.relay_mask  (results.relay_mask),
		.phase       (results.phase),
		.active_banks(results.active_banks)
	);

endmodule

/* design/lbrs_ctrl.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer controller
// Steps each item through capture, update, optional sort rounds, launch of
// the first bank and publication of the result.
// ----------------------------------------------------------------------------
module lbrs_ctrl
	import lbrs_pkg::*;
#(
	parameter int NUM_BANKS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  lbrs_status_t status,
	output lbrs_cmd_t    cmd
);

	localparam int RCW = $clog2(NUM_BANKS);
	localparam logic [RCW-1:0] LAST_ROUND = RCW'(NUM_BANKS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_SORT   = 5'b00100,
		S_LAUNCH = 5'b01000,
		S_PUB    = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [RCW-1:0] round_q, round_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		round_d = round_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				round_d  = '0;
				state_d  = status.sort_req ? S_SORT : S_PUB;
			end
			S_SORT: begin
				cmd.sort_round = 1'b1;
				cmd.sort_odd   = round_q[0];
				round_d        = round_q + 1'b1;
				if (round_q == LAST_ROUND) begin
					state_d = S_LAUNCH;
				end
			end
			S_LAUNCH: begin
				cmd.launch = 1'b1;
				state_d    = S_PUB;
			end
			S_PUB: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

endmodule

/* design/lbrs_dpath.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer datapath
// Configuration, timebase, probe and sequencing state, the odd-even sort
// lanes and the result register.
// ----------------------------------------------------------------------------
module lbrs_dpath
	import lbrs_pkg::*;
#(
	parameter int NUM_BANKS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 func,
	input  logic [CUR_W-1:0]     current_sq,
	input  lbrs_cmd_t            cmd,
	output lbrs_status_t         status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [MASK_W-1:0]    relay_mask,
	output logic [PHASE_W-1:0]   phase,
	output logic [ACTIVE_W-1:0]  active_banks
);

	localparam int BW = $clog2(NUM_BANKS);
	localparam int AW = $clog2(NUM_BANKS + 1);
	localparam int RW = (NUM_BANKS > MASK_W) ? NUM_BANKS : MASK_W;
	localparam int CW = (AW > ACTIVE_W) ? AW : ACTIVE_W;
	localparam logic [BW-1:0] LAST_BANK = BW'(NUM_BANKS - 1);
	localparam logic [AW-1:0] ALL_ON    = AW'(NUM_BANKS);

	// configuration
	logic [CUR_W-1:0] limit_q;
	logic             test_q;

	// captured item
	logic             func_q;
	logic [CUR_W-1:0] value_q;

	// sequencing state
	phase_t              phase_q, phase_d;
	logic [BW-1:0]       pbank_q, pbank_d;
	logic [PCD_W-1:0]    pcd_q, pcd_d;
	logic [SCD_W-1:0]    scd_q, scd_d;
	logic [PRE_W-1:0]    pre_q, pre_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [ELAP_W-1:0]   elap_q, elap_d;
	logic [AW-1:0]       active_q, active_d;
	logic [BW-1:0]       order_q [NUM_BANKS];
	logic [BW-1:0]       order_d [NUM_BANKS];
	logic [CUR_W-1:0]    reading_q [NUM_BANKS];
	logic [CUR_W-1:0]    reading_d [NUM_BANKS];
	logic [NUM_BANKS-1:0] failed_q, failed_d;
	logic                just_q, just_d;
	logic [NUM_BANKS-1:0] relay_q, relay_d;

	// result register
	logic                out_valid_q;
	logic [MASK_W-1:0]   mask_q;
	logic [PHASE_W-1:0]  phase_out_q;
	logic [ACTIVE_W-1:0] active_out_q;

	logic             over;
	logic [PCD_W-1:0] pcd_cut;
	logic [PCD_W-1:0] probe_load;
	logic [AW-1:0]    pos;
	logic [BW-1:0]    pos_i;
	logic             do_begin;
	logic             do_switch;
	logic             act;
	logic [RW-1:0]    relay_ext;
	logic [CW-1:0]    active_ext;

	assign over       = (value_q >= limit_q);
	assign pcd_cut    = (over && (pcd_q < PROBE_CUT_BELOW)) ? '0 : pcd_q;
	assign probe_load = test_q ? PROBE_MS_TEST : PROBE_MS_RUN;
	assign pos        = active_q - 1'b1;
	assign pos_i      = pos[BW-1:0];

	// the reading that ends the last bank's probe hands over to the sort
	assign status.sort_req = (func_q == FUNC_READING) && (phase_q == PH_PROBE) &&
		(pcd_cut == '0) && (pbank_q == LAST_BANK);
	assign status.out_free = !out_valid_q || out_ready;

	always_comb begin
		phase_d   = phase_q;
		pbank_d   = pbank_q;
		pcd_d     = pcd_q;
		scd_d     = scd_q;
		pre_d     = pre_q;
		step_d    = step_q;
		elap_d    = elap_q;
		active_d  = active_q;
		order_d   = order_q;
		reading_d = reading_q;
		failed_d  = failed_q;
		just_d    = just_q;
		relay_d   = relay_q;
		do_begin  = 1'b0;
		do_switch = 1'b0;
		act       = 1'b0;

		if (cmd.exec) begin
			if (func_q == FUNC_TICK) begin
				if (pcd_q != '0) begin
					pcd_d = pcd_q - 1'b1;
				end
				if (scd_q != '0) begin
					scd_d = scd_q - 1'b1;
					if (scd_q == SCD_W'(1) && phase_q == PH_SETTLE) begin
						phase_d = PH_WAIT;
					end
				end
				if (pre_q > PRE_W'(1)) begin
					pre_d = pre_q - 1'b1;
				end else begin
					pre_d = MS_PER_SECOND;
					if (step_q != '0) begin
						step_d = step_q - 1'b1;
					end
					if (elap_q != ELAPSED_MAX) begin
						elap_d = elap_q + 1'b1;
					end
				end
			end else begin
				unique case (phase_q)
					PH_PROBE: begin
						reading_d[pbank_q] = value_q;
						pcd_d              = pcd_cut;
						if (pcd_cut == '0) begin
							relay_d[pbank_q] = 1'b0;
							if (over) begin
								reading_d[pbank_q] = '0;
								failed_d[pbank_q]  = 1'b1;
							end
							if (pbank_q != LAST_BANK) begin
								pbank_d          = pbank_q + 1'b1;
								relay_d[pbank_d] = 1'b1;
								pcd_d            = probe_load;
							end
						end
					end
					PH_WAIT: begin
						if (over) begin
							// shed the newest bank
							if (active_q == '0) begin
								do_begin = 1'b1;
							end else begin
								relay_d[order_q[pos_i]] = 1'b0;
								active_d                = pos;
								if (pos == '0) begin
									do_begin = 1'b1;
								end else begin
									if (just_q) begin
										just_d = 1'b0;
										if (pos_i != LAST_BANK) begin
											order_d[pos_i]        = order_q[pos_i + 1'b1];
											order_d[pos_i + 1'b1] = order_q[pos_i];
										end
									end
									step_d  = test_q ? SHED_WAIT_TEST : SHED_WAIT_RUN;
									phase_d = PH_WAIT;
								end
							end
						end else begin
							if (step_q == '0) begin
								step_d = test_q ? SPACING_TEST : SPACING_RUN;
								if (active_q < ALL_ON) begin
									act = 1'b1;
								end else begin
									just_d = 1'b0;
								end
							end
							if (elap_q >= RESTART_SECONDS) begin
								if (active_q < ALL_ON) begin
									elap_d   = '0;
									do_begin = 1'b1;
								end else begin
									elap_d = RESTART_SECONDS;
								end
							end
							// restart wins over a switch-on
							do_switch = act && !do_begin;
						end
					end
					PH_IDLE:   do_begin = 1'b1;
					PH_SETTLE: ;
					default:   ;
				endcase
			end
		end

		if (cmd.sort_round) begin
			for (int j = 0; j < NUM_BANKS - 1; j++) begin
				if (((j % 2) == 1) == cmd.sort_odd) begin
					if ((failed_q[j] != failed_q[j+1]) ? failed_q[j] :
						(reading_q[j+1] > reading_q[j])) begin
						order_d[j]     = order_q[j+1];
						order_d[j+1]   = order_q[j];
						reading_d[j]   = reading_q[j+1];
						reading_d[j+1] = reading_q[j];
						failed_d[j]    = failed_q[j+1];
						failed_d[j+1]  = failed_q[j];
					end
				end
			end
		end

		if (cmd.launch) begin
			step_d    = FIRST_SPACING;
			elap_d    = '0;
			active_d  = '0;
			do_switch = 1'b1;
		end

		if (do_begin) begin
			relay_d = '0;
			for (int j = 0; j < NUM_BANKS; j++) begin
				order_d[j] = BW'(j);
			end
			failed_d   = '0;
			pbank_d    = '0;
			relay_d[0] = 1'b1;
			pcd_d      = probe_load;
			phase_d    = PH_PROBE;
		end

		if (do_switch) begin
			relay_d[order_q[active_d[BW-1:0]]] = 1'b1;
			active_d = active_d + 1'b1;
			just_d   = 1'b1;
			scd_d    = SETTLE_MS;
			phase_d  = PH_SETTLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			test_q   <= 1'b0;
			phase_q  <= PH_IDLE;
			pbank_q  <= '0;
			pcd_q    <= '0;
			scd_q    <= '0;
			pre_q    <= MS_PER_SECOND;
			step_q   <= '0;
			elap_q   <= '0;
			active_q <= '0;
			for (int j = 0; j < NUM_BANKS; j++) begin
				order_q[j]   <= BW'(j);
				reading_q[j] <= '0;
			end
			failed_q    <= '0;
			just_q      <= 1'b0;
			relay_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CURRENT_LIMIT: limit_q <= cfg_data[CUR_W-1:0];
					CFG_TEST_MODE:     test_q  <= cfg_data[0];
					default:           ;
				endcase
			end
			phase_q   <= phase_d;
			pbank_q   <= pbank_d;
			pcd_q     <= pcd_d;
			scd_q     <= scd_d;
			pre_q     <= pre_d;
			step_q    <= step_d;
			elap_q    <= elap_d;
			active_q  <= active_d;
			order_q   <= order_d;
			reading_q <= reading_d;
			failed_q  <= failed_d;
			just_q    <= just_d;
			relay_q   <= relay_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign relay_ext  = RW'(relay_q);
	assign active_ext = CW'(active_q);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			value_q <= current_sq;
		end
		if (cmd.publish) begin
			mask_q       <= relay_ext[MASK_W-1:0];
			phase_out_q  <= phase_q;
			active_out_q <= active_ext[ACTIVE_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign relay_mask   = mask_q;
	assign phase        = phase_out_q;
	assign active_banks = active_out_q;

endmodule

/* design/lbrs_checker.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "load_bank_relay_sequencer_assert.svh"

module lbrs_checker
	import lbrs_pkg::*;
#(
	parameter int NUM_BANKS = 4
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [MASK_W-1:0]   relay_mask,
	input logic [PHASE_W-1:0]  phase,
	input logic [ACTIVE_W-1:0] active_banks
);

	localparam logic FULL_MASK = (NUM_BANKS <= MASK_W);

	`LBRS_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`LBRS_ASSERT_NEXT(a_payload_hold, clk, arst_n, out_valid && !out_ready, $stable(relay_mask) && $stable(phase) && $stable(active_banks), "result changed while stalled")
	`LBRS_ASSERT_SAME(a_probe_one, clk, arst_n, out_valid && (phase == PH_PROBE), $countones(relay_mask) <= 1, "more than one relay closed while probing")
	`LBRS_ASSERT_SAME(a_on_count, clk, arst_n, FULL_MASK && out_valid && (phase == PH_SETTLE || phase == PH_WAIT), $countones(relay_mask) == active_banks, "closed relays disagree with bank count")
	`LBRS_ASSERT_SAME(a_idle_open, clk, arst_n, out_valid && (phase == PH_IDLE), relay_mask == '0 && active_banks == '0, "relay closed before start")

endmodule

bind load_bank_relay_sequencer lbrs_checker #(
	.NUM_BANKS(NUM_BANKS)
) u_lbrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.relay_mask  (results.relay_mask),
	.phase       (results.phase),
	.active_banks(results.active_banks)
);

/* tb/tb_load_bank_relay_sequencer.sv */
// ----------------------------------------------------------------------------
// Load bank relay sequencer testbench
// Drives ticks and current readings through the input channel and checks
// every status item against a cycle-free model of probing, ordering,
// switch-on and shedding, kept in step at each accepted input transfer.
// ----------------------------------------------------------------------------
module tb_load_bank_relay_sequencer;
	import lbrs_pkg::*;

	localparam int BANKS = 4;
	localparam int unsigned CYCLE_LIMIT = 20_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CUR_MAX = 16384;

	typedef struct packed {
		logic [MASK_W-1:0]   relays;
		logic [PHASE_W-1:0]  phase;
		logic [ACTIVE_W-1:0] active;
	} bank_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	lbrs_in_if  items_if ();
	lbrs_out_if results_if ();

	load_bank_relay_sequencer #(
		.NUM_BANKS(BANKS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.items    (items_if),
		.results  (results_if)
	);

	// Sequencer model state
	logic [CUR_W-1:0]    limit_sq;
	logic                short_timing;
	phase_t              phase_now;
	logic [1:0]          probe_idx;
	logic [PCD_W-1:0]    probe_left;
	logic [SCD_W-1:0]    settle_left;
	logic [PRE_W-1:0]    ms_div;
	logic [STEP_W-1:0]   spacing_s;
	logic [ELAP_W-1:0]   run_s;
	logic [ACTIVE_W-1:0] banks_on;
	logic [1:0]          bank_seq [BANKS];
	logic [CUR_W-1:0]    bank_level [BANKS];
	logic                bank_bad [BANKS];
	logic                fresh_bank;
	logic [MASK_W-1:0]   relays;

	bank_status_t status_due_q [$];
	int unsigned  mismatch_count;
	int unsigned  result_count;
	int unsigned  cycle_count;
	int unsigned  tick_allowance;
	int unsigned  rx_hold;
	logic         hold_request;
	logic         no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic void reset_model();
		limit_sq = LIMIT_RESET;
		short_timing = 1'b0;
		phase_now = PH_IDLE;
		probe_idx = '0;
		probe_left = '0;
		settle_left = '0;
		ms_div = MS_PER_SECOND;
		spacing_s = '0;
		run_s = '0;
		banks_on = '0;
		for (int i = 0; i < BANKS; i++) begin
			bank_seq[i] = 2'(i);
			bank_level[i] = '0;
			bank_bad[i] = 1'b0;
		end
		fresh_bank = 1'b0;
		relays = '0;
	endfunction

	function automatic void start_probe();
		relays = '0;
		for (int i = 0; i < BANKS; i++) begin
			bank_seq[i] = 2'(i);
			bank_bad[i] = 1'b0;
		end
		probe_idx = '0;
		relays[0] = 1'b1;
		probe_left = short_timing ? PROBE_MS_TEST : PROBE_MS_RUN;
		phase_now = PH_PROBE;
	endfunction

	// Fixed compare-swap network: failed banks last, then descending reading.
	function automatic void order_banks();
		logic [1:0] a;
		logic [1:0] b;
		logic       swap;
		for (int i = 0; i + 1 < BANKS; i++) begin
			for (int k = i + 1; k > 0; k--) begin
				a = bank_seq[k];
				b = bank_seq[k-1];
				if (bank_bad[a] != bank_bad[b])
					swap = bank_bad[b];
				else
					swap = bank_level[a] > bank_level[b];
				if (swap) begin
					bank_seq[k] = b;
					bank_seq[k-1] = a;
				end
			end
		end
	endfunction

	function automatic void switch_on_next();
		relays[bank_seq[banks_on[1:0]]] = 1'b1;
		banks_on = banks_on + 1'b1;
		fresh_bank = 1'b1;
		settle_left = SETTLE_MS;
		phase_now = PH_SETTLE;
	endfunction

	function automatic void probe_reading_in(logic [CUR_W-1:0] v);
		logic [1:0] b;
		logic       over;
		b = probe_idx;
		over = v >= limit_sq;
		bank_level[b] = v;
		if (over && probe_left < PROBE_CUT_BELOW)
			probe_left = '0;
		if (probe_left != 0)
			return;
		relays[b] = 1'b0;
		if (over) begin
			bank_level[b] = '0;
			bank_bad[b] = 1'b1;
		end
		if (int'(b) + 1 < BANKS) begin
			probe_idx = b + 1'b1;
			relays[probe_idx] = 1'b1;
			probe_left = short_timing ? PROBE_MS_TEST : PROBE_MS_RUN;
			return;
		end
		order_banks();
		spacing_s = FIRST_SPACING;
		run_s = '0;
		banks_on = '0;
		switch_on_next();
	endfunction

	function automatic void shed_newest();
		logic [ACTIVE_W-1:0] pos;
		logic [1:0]          t;
		if (banks_on == 0) begin
			start_probe();
			return;
		end
		pos = banks_on - 1'b1;
		relays[bank_seq[pos[1:0]]] = 1'b0;
		banks_on = pos;
		if (banks_on == 0) begin
			start_probe();
			return;
		end
		if (fresh_bank) begin
			fresh_bank = 1'b0;
			if (int'(pos) + 1 < BANKS) begin
				t = bank_seq[pos[1:0]];
				bank_seq[pos[1:0]] = bank_seq[pos[1:0] + 2'd1];
				bank_seq[pos[1:0] + 2'd1] = t;
			end
		end
		spacing_s = short_timing ? SHED_WAIT_TEST : SHED_WAIT_RUN;
		phase_now = PH_WAIT;
	endfunction

	function automatic void wait_reading_in(logic [CUR_W-1:0] v);
		logic activate;
		activate = 1'b0;
		if (v >= limit_sq) begin
			shed_newest();
			return;
		end
		if (spacing_s == 0) begin
			spacing_s = short_timing ? SPACING_TEST : SPACING_RUN;
			if (int'(banks_on) < BANKS)
				activate = 1'b1;
			else
				fresh_bank = 1'b0;
		end
		if (run_s >= RESTART_SECONDS) begin
			if (int'(banks_on) < BANKS) begin
				run_s = '0;
				start_probe();
				return;
			end
			run_s = RESTART_SECONDS;
		end
		if (activate)
			switch_on_next();
	endfunction

	function automatic void tick_ms();
		if (probe_left != 0)
			probe_left = probe_left - 1'b1;
		if (settle_left != 0) begin
			settle_left = settle_left - 1'b1;
			if (settle_left == 0 && phase_now == PH_SETTLE)
				phase_now = PH_WAIT;
		end
		if (ms_div > 1) begin
			ms_div = ms_div - 1'b1;
		end else begin
			ms_div = MS_PER_SECOND;
			if (spacing_s != 0)
				spacing_s = spacing_s - 1'b1;
			if (run_s != ELAPSED_MAX)
				run_s = run_s + 1'b1;
		end
	endfunction

	function automatic void advance_sequencer(logic f, logic [CUR_W-1:0] v);
		bank_status_t s;
		if (f == FUNC_TICK) begin
			tick_ms();
		end else begin
			case (phase_now)
				PH_PROBE: probe_reading_in(v);
				PH_WAIT:  wait_reading_in(v);
				PH_IDLE:  start_probe();
				default: ;
			endcase
		end
		s.relays = relays;
		s.phase = phase_now;
		s.active = banks_on;
		status_due_q.push_back(s);
	endfunction

	function automatic int unsigned ms_to_spacing_zero();
		if (spacing_s == 0)
			return 0;
		return int'(ms_div) + (int'(spacing_s) - 1) * 1000;
	endfunction

	// ------------------------------------------------------- value choices

	function automatic logic [CUR_W-1:0] pick_any();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CUR_W'(CUR_MAX);
			default: return CUR_W'($urandom_range(0, CUR_MAX));
		endcase
	endfunction

	function automatic logic [CUR_W-1:0] pick_over();
		int unsigned lo;
		lo = int'(limit_sq);
		case ($urandom_range(0, 3))
			0: return CUR_W'(lo);
			1: return CUR_W'(CUR_MAX);
			default: return CUR_W'($urandom_range(lo, CUR_MAX));
		endcase
	endfunction

	// Falls back to an over-limit value when the limit is zero.
	function automatic logic [CUR_W-1:0] pick_below();
		int unsigned hi;
		if (limit_sq == 0)
			return pick_over();
		hi = int'(limit_sq) - 1;
		case ($urandom_range(0, 3))
			0: return CUR_W'(hi);
			1: return '0;
			default: return CUR_W'($urandom_range(0, hi));
		endcase
	endfunction

	// ------------------------------------------------------------ drivers

	task automatic send_item(input logic f, input logic [CUR_W-1:0] v);
		int unsigned gap;
		if (!no_idle && $urandom_range(0, 15) == 0) begin
			gap = $urandom_range(1, 17);
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.func <= f;
		items_if.current_sq <= v;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		advance_sequencer(f, v);
	endtask

	task automatic send_reading(input logic [CUR_W-1:0] v);
		send_item(FUNC_READING, v);
	endtask

	// mode 0: ticks only, 1: odd below-limit readings, 2: odd readings of any value
	task automatic run_ticks(input int unsigned n, input int mode);
		for (int unsigned i = 0; i < n; i++) begin
			if (mode == 1 && $urandom_range(0, 299) == 0 && limit_sq != 0)
				send_reading(pick_below());
			else if (mode == 2 && $urandom_range(0, 29) == 0)
				send_reading(pick_any());
			send_item(FUNC_TICK, pick_any());
		end
		tick_allowance = (tick_allowance > n) ? tick_allowance - n : 0;
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		while (status_due_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CURRENT_LIMIT)
			limit_sq = d;
		else if (idx == CFG_TEST_MODE)
			short_timing = d[0];
		@(posedge clk);
	endtask

	task automatic set_test_mode(input logic on);
		write_reg(CFG_TEST_MODE, {CFG_DAT_W'($urandom_range(0, 16383)), on});
	endtask

	// ---------------------------------------------------- random sequencing

	// Choose a stimulus move from the modelled phase so most sequences get deep.
	task automatic random_step();
		int unsigned r;
		int unsigned cost;
		r = $urandom_range(0, 99);
		case (phase_now)
			PH_IDLE: begin
				if (r < 30)
					run_ticks($urandom_range(1, 5), 0);
				send_reading(pick_any());
			end
			PH_PROBE: begin
				if (r < 35) begin
					if (!short_timing && probe_left >= PROBE_CUT_BELOW && r < 25)
						run_ticks(int'(probe_left) - int'(PROBE_CUT_BELOW) + 1, 1);
					send_reading(pick_over());
				end else if (r < 70 && probe_left <= 2500 && probe_left <= tick_allowance) begin
					run_ticks(int'(probe_left), 1);
					if ($urandom_range(0, 4) == 0)
						send_reading(pick_over());
					else
						send_reading(pick_below());
				end else begin
					run_ticks($urandom_range(1, 20), 0);
					send_reading(pick_below());
				end
			end
			PH_SETTLE: begin
				if (r < 20)
					send_reading(pick_any());
				run_ticks(int'(settle_left), 2);
			end
			default: begin
				cost = ms_to_spacing_zero();
				if (r < 30) begin
					send_reading(pick_over());
				end else if (r < 80 && cost <= 12000 && cost <= tick_allowance) begin
					run_ticks(cost, 1);
					send_reading(pick_below());
				end else begin
					run_ticks($urandom_range(1, 30), 0);
					send_reading(pick_below());
				end
			end
		endcase
	endtask

	// limit_kind 0: any in-range limit above zero, 1: the extremes
	task automatic random_run(input int steps, input int every, input int limit_kind);
		logic [CFG_DAT_W-1:0] lim;
		for (int s = 0; s < steps; s++) begin
			if (s % every == 0) begin
				drain();
				if (limit_kind == 1) begin
					case ($urandom_range(0, 3))
						0: lim = '0;
						1: lim = CFG_DAT_W'(1);
						2: lim = CFG_DAT_W'(CUR_MAX - 1);
						default: lim = CFG_DAT_W'(CUR_MAX);
					endcase
				end else begin
					lim = CFG_DAT_W'($urandom_range(1, CUR_MAX));
				end
				write_reg(CFG_CURRENT_LIMIT, lim);
			end
			random_step();
		end
		drain();
	endtask

	// --------------------------------------------------------------- tests

	task automatic test_idle_start();
		send_item(FUNC_TICK, 15'd0);
		send_item(FUNC_TICK, CUR_W'(CUR_MAX));
		send_item(FUNC_TICK, 15'd16383);
		send_reading(15'd0);
	endtask

	// Operational timings at the reset limit: the early-stop window edge and one full probe.
	task automatic test_run_mode_probe();
		send_reading(CUR_W'(CUR_MAX));
		run_ticks(250, 0);
		send_reading(limit_sq);
		run_ticks(1, 0);
		send_reading(limit_sq);
		send_reading(limit_sq - 1'b1);
		run_ticks(int'(probe_left), 0);
		send_reading(limit_sq - 1'b1);
		run_ticks(251, 0);
		send_reading(CUR_W'(CUR_MAX));
		run_ticks(251, 0);
		send_reading(15'd200);
		send_reading(CUR_W'(CUR_MAX));
		run_ticks(int'(settle_left), 0);
		// shed the only bank on: probing starts over
		send_reading(15'd101);
		drain();
	endtask

	task automatic test_sequence_and_shed();
		set_test_mode(1'b1);
		write_reg(CFG_CURRENT_LIMIT, 15'd5000);
		run_ticks(251, 0);
		send_reading(15'd6000);
		run_ticks(int'(probe_left), 0);
		send_reading(15'd3000);
		send_reading(CUR_W'(CUR_MAX));
		run_ticks(int'(probe_left), 0);
		send_reading(15'd3000);
		run_ticks(int'(settle_left), 0);
		run_ticks(ms_to_spacing_zero(), 0);
		send_reading(15'd0);
		run_ticks(int'(settle_left), 0);
		// shed the bank just added: it moves one place later
		send_reading(15'd5000);
		run_ticks(ms_to_spacing_zero(), 0);
		send_reading(15'd4999);
		for (int i = 0; i < 2; i++) begin
			run_ticks(int'(settle_left), 0);
			run_ticks(ms_to_spacing_zero(), 0);
			send_reading(15'd1);
		end
		run_ticks(int'(settle_left), 0);
		// just added in the last position: no swap
		send_reading(15'd7000);
		run_ticks(ms_to_spacing_zero(), 0);
		send_reading(15'd10);
		run_ticks(int'(settle_left), 0);
		run_ticks(ms_to_spacing_zero(), 0);
		send_reading(15'd20);
		send_reading(15'd30);
		send_reading(15'd9000);
		drain();
	endtask

	task automatic test_limit_extremes();
		write_reg(CFG_CURRENT_LIMIT, '0);
		repeat (3) send_reading(15'd0);
		repeat (4) send_reading(15'd0);
		run_ticks(int'(settle_left), 0);
		send_reading(15'd0);
		drain();
		write_reg(CFG_CURRENT_LIMIT, CFG_DAT_W'(CUR_MAX));
		send_reading(15'd16383);
		send_reading(CUR_W'(CUR_MAX));
		drain();
	endtask

	task automatic test_backpressure();
		hold_request <= 1'b1;
		run_ticks(120, 0);
		drain();
	endtask

	task automatic test_random_short_timing();
		set_test_mode(1'b1);
		tick_allowance = 50000;
		random_run(320, 60, 0);
	endtask

	task automatic test_random_extreme_limits();
		tick_allowance = 10000;
		random_run(120, 30, 1);
	endtask

	task automatic test_random_run_timing();
		set_test_mode(1'b0);
		tick_allowance = 10000;
		random_run(150, 50, 0);
	endtask

	task automatic test_quiet_tail();
		no_idle <= 1'b1;
		set_test_mode(1'b1);
		tick_allowance = 5000;
		random_run(100, 50, 0);
	endtask

	// ------------------------------------------------------ result side

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request <= 1'b0;
			rx_hold <= HOLD_CYCLES;
			results_if.ready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			results_if.ready <= (rx_hold == 1);
		end else if (!no_idle && $urandom_range(0, 15) == 0) begin
			rx_hold <= $urandom_range(1, 17);
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bank_status_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			result_count <= result_count + 1;
			if (status_due_q.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("unexpected result %0d: mask %b phase %0d active %0d",
						result_count, results_if.relay_mask, results_if.phase,
						results_if.active_banks);
			end else begin
				want = status_due_q.pop_front();
				if (results_if.relay_mask !== want.relays || results_if.phase !== want.phase
						|| results_if.active_banks !== want.active) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display({"mismatch at result %0d: expected mask %b phase %0d ",
							"active %0d, got mask %b phase %0d active %0d"},
							result_count, want.relays, want.phase, want.active,
							results_if.relay_mask, results_if.phase,
							results_if.active_banks);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------ sequence

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.func = FUNC_TICK;
		items_if.current_sq = '0;
		results_if.ready = 1'b0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		rx_hold = 0;
		mismatch_count = 0;
		result_count = 0;
		cycle_count = 0;
		tick_allowance = 0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_start();
		test_run_mode_probe();
		test_sequence_and_shed();
		test_limit_extremes();
		test_backpressure();
		test_random_short_timing();
		test_random_extreme_limits();
		test_random_run_timing();
		test_quiet_tail();

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && status_due_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* load_bank_relay_sequencer.f */
+incdir+design
design/lbrs_pkg.sv
design/lbrs_channels.sv
design/lbrs_ctrl.sv
design/lbrs_dpath.sv
design/load_bank_relay_sequencer.sv
design/lbrs_checker.sv
tb/tb_load_bank_relay_sequencer.sv
